[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker of the temperature report formatter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/trf_pkg.sv]
// ----------------------------------------------------------------------------
// trf_pkg
// Types and constants shared by the temperature report formatter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

    // Item kinds carried in the input tuser
    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_HOST   = 2'd1,
        MODE_TICK   = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ALARM_HIGH = 1'b0,
        REG_ALARM_LOW  = 1'b1
    } reg_index_t;

    localparam int ALARM_W  = 7;
    localparam int SAMPLE_W = 10;
    localparam int HUND_W   = 14;
    localparam int POS_W    = 3;

    // Scaling: p = (sample - offset) * gain, hundredths = p * 100 / 1024
    localparam int SENSOR_OFFSET = 673;
    localparam int SCALE_GAIN    = 423;
    localparam int HUND_GAIN     = 100;
    localparam int FRAC_BITS     = 10;
    localparam logic [HUND_W-1:0] HUND_MAX = 14'd9999;

    // Characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_K     = 8'h4B;
    localparam logic [7:0] CHAR_Q     = 8'h51;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Reset values and limits
    localparam logic [ALARM_W-1:0] ALARM_HIGH_RESET = 7'd25;
    localparam logic [ALARM_W-1:0] ALARM_LOW_RESET  = 7'd15;
    localparam logic [3:0] PERIOD_RESET = 4'd5;
    localparam logic [3:0] PERIOD_MIN   = 4'd2;
    localparam logic [3:0] PERIOD_MAX   = 4'd9;
    localparam logic [1:0] PHASE_RESET  = 2'd1;
    localparam logic [1:0] PHASE_SET    = 2'd1;
    localparam logic [1:0] PHASE_CLEAR  = 2'd2;
    localparam logic [1:0] PHASE_WRAP   = 2'd3;

    // Character positions in a report
    localparam logic [POS_W-1:0] POS_TENS   = 3'd0;
    localparam logic [POS_W-1:0] POS_ONES   = 3'd1;
    localparam logic [POS_W-1:0] POS_DOT    = 3'd2;
    localparam logic [POS_W-1:0] POS_TENTHS = 3'd3;
    localparam logic [POS_W-1:0] POS_HUNDS  = 3'd4;

    // Report job handed from the front to the back
    typedef struct packed {
        logic [HUND_W-1:0] hund;
        logic              led;
        logic              send;
        logic [POS_W-1:0]  last_pos;
    } desc_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

[hw/rtl/trf_queue.sv]
// ----------------------------------------------------------------------------
// trf_queue
// Short register queue of report jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire trf_pkg::desc_t     push_data,
    input  wire logic               pop,
    output trf_pkg::desc_t          head,
    output trf_pkg::q_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    trf_pkg::desc_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    // Guard the pointers against overrun and underrun
    always_comb
    begin
        do_push     = push && (count_reg != CNT_FULL);
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

[hw/rtl/trf_front.sv]
// ----------------------------------------------------------------------------
// trf_front
// Accepts items, scales samples and keeps command, period, tick and LED state.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   in_mode,
    input  wire logic [trf_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic [7:0]                   in_rx_byte,
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [trf_pkg::ALARM_W-1:0]  cfg_data,
    input  wire trf_pkg::q_status_t           q_status,
    output logic                              push,
    output trf_pkg::desc_t                    push_data
);

    // Stage 1: accepted item with the scaled product
    logic                s1_valid_reg, s1_valid_next;
    trf_pkg::mode_t      s1_mode_reg;
    logic [7:0]          s1_rx_reg;
    logic signed [19:0]  s1_p_reg, s1_p_next;
    logic signed [10:0]  diff;
    logic                in_accept;
    logic                s2_fire;

    // Architectural state
    logic [trf_pkg::ALARM_W-1:0] alarm_high_reg, alarm_low_reg;
    logic [7:0] cmd_reg, cmd_next;
    logic [3:0] period_reg, period_next;
    logic [3:0] tick_reg, tick_next;
    logic [1:0] phase_reg, phase_next;
    logic       flag_reg, flag_next;
    logic       led_reg, led_next;

    // Stage 2 arithmetic
    logic signed [19:0]  p_adj;
    logic signed [9:0]   whole;
    logic [24:0]         hund_prod;
    logic [14:0]         hund_raw;
    logic [trf_pkg::HUND_W-1:0] hund;
    logic                alarm_hit;

    // Accept a new item when stage 1 is empty or drains this cycle
    assign s2_fire   = s1_valid_reg &&
                       ((s1_mode_reg != trf_pkg::MODE_SAMPLE) || !q_status.full);
    assign in_ready  = !s1_valid_reg || s2_fire;
    assign in_accept = in_valid && in_ready;

    assign diff      = $signed({1'b0, in_sample}) - 11'sd673;
    assign s1_p_next = 20'(diff) * 20'(trf_pkg::SCALE_GAIN);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= trf_pkg::mode_t'(in_mode);
            s1_rx_reg   <= in_rx_byte;
            s1_p_reg    <= s1_p_next;
        end
    end

    // Whole degrees truncated toward zero, hundredths saturated to 0..99.99
    assign p_adj     = s1_p_reg + (s1_p_reg[19] ? 20'sd1023 : 20'sd0);
    assign whole     = $signed(p_adj[19:trf_pkg::FRAC_BITS]);
    assign hund_prod = 25'(s1_p_reg[17:0]) * 25'(trf_pkg::HUND_GAIN);
    assign hund_raw  = hund_prod[24:trf_pkg::FRAC_BITS];
    assign alarm_hit = (whole >= $signed({3'b000, alarm_high_reg})) ||
                       (whole <= $signed({3'b000, alarm_low_reg}));

    always_comb
    begin
        if (s1_p_reg[19])
        begin
            hund = '0;
        end
        else if (hund_raw > 15'(trf_pkg::HUND_MAX))
        begin
            hund = trf_pkg::HUND_MAX;
        end
        else
        begin
            hund = hund_raw[trf_pkg::HUND_W-1:0];
        end
    end

    // Stage 2: apply the item to the state, queue a report job for samples
    always_comb
    begin
        logic [3:0] tc;
        logic [1:0] ph;
        logic [3:0] per;
        logic [7:0] cmd;

        cmd_next    = cmd_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        phase_next  = phase_reg;
        flag_next   = flag_reg;
        led_next    = led_reg;
        push        = 1'b0;
        push_data   = '0;
        tc          = tick_reg;
        ph          = phase_reg;
        per         = period_reg;
        cmd         = cmd_reg;

        if (s2_fire)
        begin
            case (s1_mode_reg)
                trf_pkg::MODE_SAMPLE:
                begin
                    led_next = alarm_hit ? !led_reg : 1'b0;
                    if (cmd == trf_pkg::CHAR_M)
                    begin
                        per = per + 1'b1;
                        cmd = trf_pkg::CHAR_Q;
                    end
                    if (cmd == trf_pkg::CHAR_K)
                    begin
                        per = per - 1'b1;
                        cmd = trf_pkg::CHAR_Q;
                    end
                    if (per < trf_pkg::PERIOD_MIN)
                    begin
                        per = trf_pkg::PERIOD_MIN;
                    end
                    if (per >= trf_pkg::PERIOD_MAX)
                    begin
                        per = trf_pkg::PERIOD_MAX;
                    end
                    cmd_next    = cmd;
                    period_next = per;
                    flag_next   = 1'b0;

                    push               = 1'b1;
                    push_data.hund     = hund;
                    push_data.led      = led_next;
                    push_data.send     = flag_reg;
                    if (cmd == trf_pkg::CHAR_ZERO)
                    begin
                        push_data.last_pos = trf_pkg::POS_ONES;
                    end
                    else if (cmd == trf_pkg::CHAR_ONE)
                    begin
                        push_data.last_pos = trf_pkg::POS_TENTHS;
                    end
                    else
                    begin
                        push_data.last_pos = trf_pkg::POS_HUNDS;
                    end
                end
                trf_pkg::MODE_HOST:
                begin
                    cmd_next = s1_rx_reg;
                end
                trf_pkg::MODE_TICK:
                begin
                    if ({1'b0, tc} >= ({1'b0, period_reg} + 5'd1))
                    begin
                        tc = 4'd1;
                    end
                    if (tc == period_reg)
                    begin
                        if (ph >= trf_pkg::PHASE_WRAP)
                        begin
                            ph = trf_pkg::PHASE_SET;
                        end
                        if (ph == trf_pkg::PHASE_SET)
                        begin
                            flag_next = 1'b1;
                        end
                        else if (ph == trf_pkg::PHASE_CLEAR)
                        begin
                            flag_next = 1'b0;
                        end
                        phase_next = ph + 1'b1;
                    end
                    tick_next = tc + 1'b1;
                end
                default:
                begin
                    // Unused kind: drop the item
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_high_reg <= trf_pkg::ALARM_HIGH_RESET;
            alarm_low_reg  <= trf_pkg::ALARM_LOW_RESET;
            cmd_reg        <= trf_pkg::CHAR_SPACE;
            period_reg     <= trf_pkg::PERIOD_RESET;
            tick_reg       <= '0;
            phase_reg      <= trf_pkg::PHASE_RESET;
            flag_reg       <= 1'b0;
            led_reg        <= 1'b0;
        end
        else
        begin
            cmd_reg    <= cmd_next;
            period_reg <= period_next;
            tick_reg   <= tick_next;
            phase_reg  <= phase_next;
            flag_reg   <= flag_next;
            led_reg    <= led_next;
            if (cfg_we)
            begin
                case (trf_pkg::reg_index_t'(cfg_index))
                    trf_pkg::REG_ALARM_HIGH: alarm_high_reg <= cfg_data;
                    trf_pkg::REG_ALARM_LOW:  alarm_low_reg  <= cfg_data;
                    default:                 alarm_low_reg  <= alarm_low_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/trf_back.sv]
// ----------------------------------------------------------------------------
// trf_back
// Turns report jobs into characters, one per cycle unless the output stalls, via an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trf_pkg::desc_t     head,
    input  wire trf_pkg::q_status_t q_status,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    out_tx_valid,
    output logic                    out_led,
    output logic                    out_last
);

    localparam int PLACE_TENS   = 1000;
    localparam int PLACE_ONES   = 100;
    localparam int PLACE_TENTHS = 10;

    // Decimal digit of r at a fixed place, r below ten places
    function automatic logic [3:0] digit_of(input logic [trf_pkg::HUND_W-1:0] r,
                                            input int place);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (r >= trf_pkg::HUND_W'(k * place))
            begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    logic                       busy_reg, busy_next;
    logic [trf_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [trf_pkg::POS_W-1:0]  last_pos_reg, last_pos_next;
    logic [trf_pkg::HUND_W-1:0] r_reg, r_next;
    logic                       led_reg, led_next;
    logic                       send_reg, send_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_txv_reg, out_txv_next;
    logic       out_led_reg, out_led_next;
    logic       out_last_reg, out_last_next;

    logic       out_free, emit, emit_last, is_last;
    logic [3:0] d_tens, d_ones, d_tenths;

    assign d_tens   = digit_of(r_reg, PLACE_TENS);
    assign d_ones   = digit_of(r_reg, PLACE_ONES);
    assign d_tenths = digit_of(r_reg, PLACE_TENTHS);

    // Emit while working and the output slot frees; load the next job on the last
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && out_free;
    assign is_last   = !send_reg || (pos_reg == last_pos_reg);
    assign emit_last = emit && is_last;
    assign pop       = !q_status.empty && (!busy_reg || emit_last);

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        last_pos_next  = last_pos_reg;
        r_next         = r_reg;
        led_next       = led_reg;
        send_next      = send_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_txv_next   = out_txv_reg;
        out_led_next   = out_led_reg;
        out_last_next  = out_last_reg;

        // Drain the output register
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Produce the character at the current position
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_led_next   = led_reg;
            out_last_next  = is_last;
            out_txv_next   = send_reg;
            out_byte_next  = '0;
            pos_next       = pos_reg + 1'b1;
            if (send_reg)
            begin
                case (pos_reg)
                    trf_pkg::POS_TENS:
                    begin
                        out_byte_next = trf_pkg::CHAR_ZERO + 8'(d_tens);
                        r_next = r_reg - trf_pkg::HUND_W'(int'(d_tens) * PLACE_TENS);
                    end
                    trf_pkg::POS_ONES:
                    begin
                        out_byte_next = trf_pkg::CHAR_ZERO + 8'(d_ones);
                        r_next = r_reg - trf_pkg::HUND_W'(int'(d_ones) * PLACE_ONES);
                    end
                    trf_pkg::POS_DOT:
                    begin
                        out_byte_next = trf_pkg::CHAR_DOT;
                    end
                    trf_pkg::POS_TENTHS:
                    begin
                        out_byte_next = trf_pkg::CHAR_ZERO + 8'(d_tenths);
                        r_next = r_reg - trf_pkg::HUND_W'(int'(d_tenths) * PLACE_TENTHS);
                    end
                    trf_pkg::POS_HUNDS:
                    begin
                        out_byte_next = trf_pkg::CHAR_ZERO + 8'(r_reg[3:0]);
                    end
                    default:
                    begin
                        out_byte_next = '0;
                    end
                endcase
            end
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end

        // Load a new job
        if (pop)
        begin
            busy_next     = 1'b1;
            pos_next      = trf_pkg::POS_TENS;
            last_pos_next = head.last_pos;
            r_next        = head.hund;
            led_next      = head.led;
            send_next     = head.send;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        last_pos_reg <= last_pos_next;
        r_reg        <= r_next;
        led_reg      <= led_next;
        send_reg     <= send_next;
        out_byte_reg <= out_byte_next;
        out_txv_reg  <= out_txv_next;
        out_led_reg  <= out_led_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_tx_valid = out_txv_reg;
    assign out_led      = out_led_reg;
    assign out_last     = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/temperature_report_formatter.sv]
// ----------------------------------------------------------------------------
// temperature_report_formatter
// Sensor report formatter: command byte, send timer, alarm LED, ASCII digits.
// ----------------------------------------------------------------------------
// The block takes one item a cycle while its job queue has room: host bytes
// and timer ticks only update internal state, and each sensor sample waits in
// the stage 1 register until the queue has room, then enters it as a report
// job. The back turns one job into 1 to 5 results at one result per cycle from
// its output register while the output is not stalled, so a sample costs from
// 1 result (nothing to send) up to 5 (full XX.XX report) of output bandwidth;
// a separate load step is spent only when the back was idle. The job queue is
// QUEUE_DEPTH entries deep.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_report_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [9:0] sample, [17:10] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] tx_byte, [8] led_on
    output logic [0:0]       m_axis_tuser,   // [0] tx_valid
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    logic               push, pop;
    trf_pkg::desc_t     push_data, head;
    trf_pkg::q_status_t q_status;
    logic [7:0]         tx_byte;
    logic               tx_valid, led_on;

    trf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_mode    (s_axis_tuser),
        .in_sample  (s_axis_tdata[9:0]),
        .in_rx_byte (s_axis_tdata[17:10]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    trf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    trf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (tx_byte),
        .out_tx_valid (tx_valid),
        .out_led      (led_on),
        .out_last     (m_axis_tlast)
    );

    // Pack the result fields
    assign m_axis_tdata = {7'b0000000, led_on, tx_byte};
    assign m_axis_tuser = tx_valid;

endmodule

`default_nettype wire

[hw/rtl/trf_checker.sv]
// ----------------------------------------------------------------------------
// trf_checker
// Port-level checks of the temperature report formatter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // An empty result is the only one of its sample and carries no character
    `ASSERT_NOW(a_empty_result, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[7:0] == 8'h00))

    // Characters are digits or the decimal point
    `ASSERT_NOW(a_char_set, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], ((m_axis_tdata[7:0] >= 8'h30) && (m_axis_tdata[7:0] <= 8'h39)) || (m_axis_tdata[7:0] == 8'h2E))

    // The LED state is the same across all items of one report
    `ASSERT_NEXT(a_led_burst, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[8] == $past(m_axis_tdata[8])))

endmodule

bind temperature_report_formatter trf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
